>>> rtl/murmur2_stream_hash_assert.svh
// Assertion macros used by the murmur2_stream_hash checker.
`ifndef MURMUR2_STREAM_HASH_ASSERT_SVH
`define MURMUR2_STREAM_HASH_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define M2SH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is high.
`define M2SH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define M2SH_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/m2sh_pkg.sv
// Types and constants for the MurmurHash2 stream hasher.
`timescale 1ns / 1ps
`default_nettype none
package m2sh_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = 3;

  localparam logic [WORD_W-1:0] MIX_MUL     = 32'h5bd1e995;
  localparam int                MIX_SHIFT   = 24;
  localparam int                FIN_SHIFT_A = 13;
  localparam int                FIN_SHIFT_B = 15;

  // how a beat folds into the running state
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_FULL = 2'd1;
  localparam logic [1:0] KIND_TAIL = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic              first;
    logic              last;
    logic [WORD_W-1:0] init;  // seed ^ length, used when first is set
    logic [WORD_W-1:0] key;   // mixed word, or masked tail bytes
  } m2sh_entry_t;

endpackage
`default_nettype wire

>>> rtl/m2sh_if.sv
// Valid/ready stream interfaces for message words and finished hashes.
`timescale 1ns / 1ps
`default_nettype none
interface m2sh_in_if;
  import m2sh_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_word;
  logic [CNT_W-1:0]  valid_bytes;
  logic              first;
  logic              last;
  logic [WORD_W-1:0] message_length;

  modport source (output valid, data_word, valid_bytes, first, last, message_length,
                  input ready);
  modport sink   (input valid, data_word, valid_bytes, first, last, message_length,
                  output ready);
endinterface

interface m2sh_out_if;
  import m2sh_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface
`default_nettype wire

>>> rtl/m2sh_front.sv
// Front end: takes beats, classifies them and mixes full words over two stages.
`timescale 1ns / 1ps
`default_nettype none
module m2sh_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [31:0]           cfg_wdata,
  m2sh_in_if.sink                    din,
  output logic                       q_valid,
  input  wire logic                  q_ready,
  output m2sh_pkg::m2sh_entry_t      q_entry
);
  import m2sh_pkg::*;

  logic [WORD_W-1:0] seed;

  logic              s1_valid;
  logic [WORD_W-1:0] s1_prod;
  logic [WORD_W-1:0] s1_tail;
  logic [1:0]        s1_kind;
  logic              s1_first;
  logic              s1_last;
  logic [WORD_W-1:0] s1_init;

  logic              s2_valid;
  m2sh_entry_t       s2_entry;

  logic              adv1;
  logic              adv2;
  logic [1:0]        kind_in;
  logic [WORD_W-1:0] tail_in;
  logic [WORD_W-1:0] s1_mixed;

  assign adv2      = !s2_valid || q_ready;
  assign adv1      = !s1_valid || adv2;
  assign din.ready = adv1;

  always_comb begin
    tail_in = '0;
    case (din.valid_bytes)
      3'd1:    tail_in = {24'd0, din.data_word[7:0]};
      3'd2:    tail_in = {16'd0, din.data_word[15:0]};
      3'd3:    tail_in = {8'd0, din.data_word[23:0]};
      default: tail_in = '0;
    endcase
    // non-last beats always count as four bytes
    if (!din.last || din.valid_bytes >= 3'd4) begin
      kind_in = KIND_FULL;
    end else if (din.valid_bytes == 3'd0) begin
      kind_in = KIND_NONE;
    end else begin
      kind_in = KIND_TAIL;
    end
  end

  assign s1_mixed = s1_prod ^ (s1_prod >> MIX_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_we) begin
      seed <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= din.valid;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && din.valid) begin
      s1_prod  <= WORD_W'(din.data_word * MIX_MUL);
      s1_tail  <= tail_in;
      s1_kind  <= kind_in;
      s1_first <= din.first;
      s1_last  <= din.last;
      s1_init  <= seed ^ din.message_length;
    end
    if (adv2 && s1_valid) begin
      s2_entry.kind  <= s1_kind;
      s2_entry.first <= s1_first;
      s2_entry.last  <= s1_last;
      s2_entry.init  <= s1_init;
      s2_entry.key   <= (s1_kind == KIND_FULL) ? WORD_W'(s1_mixed * MIX_MUL) : s1_tail;
    end
  end

  assign q_valid = s2_valid;
  assign q_entry = s2_entry;

endmodule
`default_nettype wire

>>> rtl/m2sh_queue.sv
// Small FIFO of classified beats between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module m2sh_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push_valid,
  output logic                       push_ready,
  input  m2sh_pkg::m2sh_entry_t      push_entry,
  output logic                       pop_valid,
  input  wire logic                  pop_ready,
  output m2sh_pkg::m2sh_entry_t      pop_entry
);
  import m2sh_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  m2sh_entry_t    slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule
`default_nettype wire

>>> rtl/m2sh_back.sv
// Back end: folds keys into the running hash and runs the final avalanche.
`timescale 1ns / 1ps
`default_nettype none
module m2sh_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  m2sh_pkg::m2sh_entry_t      q_entry,
  m2sh_out_if.source                 dout
);
  import m2sh_pkg::*;

  logic [WORD_W-1:0] running_hash;
  logic              fin_pend;
  logic              out_valid;
  logic [WORD_W-1:0] out_prod;

  logic              out_free;
  logic              fin_go;
  logic              take;
  logic [WORD_W-1:0] base;
  logic [WORD_W-1:0] hash_next;
  logic [WORD_W-1:0] fin_pre;

  assign out_free = !out_valid || dout.ready;
  assign fin_go   = fin_pend && out_free;
  // a new beat may pop in the same cycle the avalanche reads the old state
  assign q_ready  = !fin_pend || fin_go;
  assign take     = q_valid && q_ready;

  assign base    = q_entry.first ? q_entry.init : running_hash;
  assign fin_pre = running_hash ^ (running_hash >> FIN_SHIFT_A);

  always_comb begin
    case (q_entry.kind)
      KIND_FULL: hash_next = WORD_W'(base * MIX_MUL) ^ q_entry.key;
      KIND_TAIL: hash_next = WORD_W'((base ^ q_entry.key) * MIX_MUL);
      default:   hash_next = base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      fin_pend     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        running_hash <= hash_next;
        fin_pend     <= q_entry.last;
      end else if (fin_go) begin
        fin_pend <= 1'b0;
      end
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_prod <= WORD_W'(fin_pre * MIX_MUL);
    end
  end

  assign dout.valid      = out_valid;
  assign dout.hash_value = out_prod ^ (out_prod >> FIN_SHIFT_B);

endmodule
`default_nettype wire

>>> rtl/murmur2_stream_hash.sv
// Top level of the streaming 32-bit MurmurHash2 engine.
//
//   channel  dir  beat carries
//   din      in   data_word, valid_bytes, first, last, message_length
//   dout     out  hash_value, one beat per last input beat
//   cfg      in   seed, written when cfg_we is high
//
// Sustained rate is one beat per cycle while dout is not stalled; the
// running-hash multiply in the back end is the only loop, and the avalanche
// overlaps the next message's first beat. A last beat's hash passes through the
// two mixing stages, the queue, the fold and the avalanche multiply register.
// Synchronous reset clears the pipeline valids, queue, running hash and seed.
// A stall on dout fills the queue; din drops ready once the front stages back up.
`timescale 1ns / 1ps
`default_nettype none
module murmur2_stream_hash #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  m2sh_in_if.sink          din,
  m2sh_out_if.source       dout
);
  import m2sh_pkg::*;

  logic        f_valid;
  logic        f_ready;
  m2sh_entry_t f_entry;
  logic        b_valid;
  logic        b_ready;
  m2sh_entry_t b_entry;

  m2sh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .din       (din),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_entry   (f_entry)
  );

  m2sh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_entry (f_entry),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_entry  (b_entry)
  );

  m2sh_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .q_entry (b_entry),
    .dout    (dout)
  );

endmodule
`default_nettype wire

>>> rtl/m2sh_checker.sv
// Port-level checks for murmur2_stream_hash, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "murmur2_stream_hash_assert.svh"
module m2sh_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_last,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_hash
);

  // last beats taken whose hash has not yet been delivered
  logic [7:0] owed;
  logic       last_in;
  logic       hash_out;

  assign last_in  = in_valid && in_ready && in_last;
  assign hash_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= '0;
    end else if (last_in && !hash_out) begin
      owed <= owed + 8'd1;
    end else if (hash_out && !last_in) begin
      owed <= owed - 8'd1;
    end
  end

  `M2SH_ASSERT_RST(a_rst_clears_out, rst, !out_valid, "result valid right after reset")
  `M2SH_ASSERT_NOW(a_result_owed, out_valid, owed != 8'd0, "result without a last beat")
  `M2SH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped in stall")
  `M2SH_ASSERT_NEXT(a_hash_stable, out_valid && !out_ready, $stable(out_hash), "hash changed in stall")

endmodule

bind murmur2_stream_hash m2sh_checker u_m2sh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (din.valid),
  .in_ready  (din.ready),
  .in_last   (din.last),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .out_hash  (dout.hash_value)
);
`default_nettype wire
